// File: src/mlht_pkg.sv
// ----------------------------------------------------------------------------
// mlht_pkg
// Types, opcodes and register indexes of the multi-level hash table.
// ----------------------------------------------------------------------------
package mlht_pkg;

  localparam int KEY_W      = 32;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int SIZE_W     = 11;
  localparam int NLAY_W     = 3;
  localparam int HIT_W      = 2;
  localparam int LUSED_W    = 11;
  localparam int TUSED_W    = 13;

  localparam int DEF_LAYERS = 4;
  localparam int DEF_SLOTS  = 1024;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_MODIFY = 3'd3;
  localparam logic [OP_W-1:0] OP_REKEY  = 3'd4;
  localparam logic [OP_W-1:0] OP_SWAP   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 3'd4;

  localparam logic [SIZE_W-1:0] RST_SIZE_0 = 11'd1021;
  localparam logic [SIZE_W-1:0] RST_SIZE_1 = 11'd1019;
  localparam logic [SIZE_W-1:0] RST_SIZE_2 = 11'd1013;
  localparam logic [SIZE_W-1:0] RST_SIZE_3 = 11'd1009;
  localparam logic [NLAY_W-1:0] RST_LAYERS = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  key_hash;
    logic [KEY_W-1:0]  second_key;
    logic [KEY_W-1:0]  second_hash;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  old_value;
    logic [HIT_W-1:0]   hit_layer;
    logic [LUSED_W-1:0] layer_used;
    logic [TUSED_W-1:0] total_used;
  } out_item_t;

endpackage

// File: src/multilevel_hash_table_top.sv
// ----------------------------------------------------------------------------
// multilevel_hash_table_top
// Multi-level hash table with key and data memories and a probe sequencer.
// ----------------------------------------------------------------------------
// One item at a time. An item first reduces its hash modulo every layer size
// with restoring remainder steps, all layers side by side, one hash bit per
// cycle. It then probes the layers through the key memory port, a read state
// and an evaluate state per layer, stopping at a match. Rekey and swap repeat
// both for the second key. Data reads and writebacks pass through the states
// VA1, VA2, VA3, W1 and W2. An item with a zero key or an unknown opcode goes
// straight to the result. After reset and for every clear, the key memory is
// swept one slot a cycle while no item is accepted. Results wait in an output
// register.
module multilevel_hash_table_top
  import mlht_pkg::*;
#(
  parameter int LAYERS          = DEF_LAYERS,
  parameter int SLOTS_PER_LAYER = DEF_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NL     = (LAYERS < 4) ? LAYERS : 4;
  localparam int LIX_W  = (NL > 1) ? $clog2(NL) : 1;
  localparam int DEPTH  = LAYERS * SLOTS_PER_LAYER;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SZ_W   = $clog2(SLOTS_PER_LAYER + 1);
  localparam int CNT_W  = $clog2(SLOTS_PER_LAYER + 1);
  localparam int TOT_W  = $clog2(DEPTH + 1);

  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PEV   = 4'd4;
  localparam logic [3:0] S_VA1   = 4'd5;
  localparam logic [3:0] S_VA2   = 4'd6;
  localparam logic [3:0] S_VA3   = 4'd7;
  localparam logic [3:0] S_W1    = 4'd8;
  localparam logic [3:0] S_W2    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;

  logic [SIZE_W-1:0] size_q [4];
  logic [NLAY_W-1:0] nlay_q;

  in_item_t item_q;
  logic     ph_q;
  logic     ok_q;
  logic [4:0] bit_q;
  logic [1:0] lcnt_q;
  logic [SZ_W-1:0] rem_q [NL];
  logic [ADDR_W-1:0] slot_q [2];
  logic [1:0] lay_q [2];
  logic match_q [2];
  logic emp_q [2];
  logic [DATA_W-1:0] v1_q, v2_q;
  logic [ADDR_W-1:0] sweep_q;

  logic [CNT_W-1:0] cnt_q [NL];
  logic [TOT_W-1:0] tot_q;

  logic out_valid_q;
  out_item_t out_q;

  logic [KEY_W-1:0]  kmem [DEPTH];
  logic [DATA_W-1:0] vmem [DEPTH];
  logic [KEY_W-1:0]  krd_q;
  logic [DATA_W-1:0] vrd_q;

  logic              kwe, kre, vwe, vre;
  logic [ADDR_W-1:0] kwa, kra, vwa, vra;
  logic [KEY_W-1:0]  kwd;
  logic [DATA_W-1:0] vwd;

  function automatic logic [SZ_W-1:0] eff_size(input logic [SIZE_W-1:0] c);
    int s;
    s = int'(c);
    if (s < 1) s = 1;
    if (s > SLOTS_PER_LAYER) s = SLOTS_PER_LAYER;
    return SZ_W'(s);
  endfunction

  logic [2:0] nl_eff;
  always_comb begin
    nl_eff = nlay_q;
    if (nlay_q == 3'd0) nl_eff = 3'd1;
    if (int'(nlay_q) > NL) nl_eff = 3'(NL);
  end

  logic [ADDR_W-1:0] probe_addr;
  assign probe_addr = ADDR_W'(lcnt_q) * ADDR_W'(SLOTS_PER_LAYER)
                    + ADDR_W'(rem_q[lcnt_q[LIX_W-1:0]]);

  logic [KEY_W-1:0]  pkey;
  logic [KEY_W-1:0]  hsrc;
  logic              or_empty;
  logic              last_lay;
  assign pkey     = ph_q ? item_q.second_key : item_q.key;
  assign hsrc     = ph_q ? item_q.second_hash : item_q.key_hash;
  assign or_empty = ph_q ? (item_q.opcode == OP_REKEY) : (item_q.opcode == OP_INSERT);
  assign last_lay = ({1'b0, lcnt_q} == nl_eff - 3'd1);

  logic pmatch, pemp;
  assign pmatch = (krd_q == pkey);
  assign pemp   = (krd_q == '0);

  logic fin_match, fin_emp;
  assign fin_match = match_q[ph_q] | pmatch;
  assign fin_emp   = emp_q[ph_q] | (pemp & or_empty);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (kwe) kmem[kwa] <= kwd;
    if (kre) krd_q <= kmem[kra];
  end

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwa] <= vwd;
    if (vre) vrd_q <= vmem[vra];
  end

  always_comb begin
    kwe = 1'b0; kwa = slot_q[0]; kwd = '0; kre = 1'b0; kra = probe_addr;
    vwe = 1'b0; vwa = slot_q[0]; vwd = item_q.value; vre = 1'b0; vra = slot_q[0];
    case (state_q)
      S_SWEEP: begin
        kwe = 1'b1;
        kwa = sweep_q;
      end
      S_PRD: kre = 1'b1;
      S_VA1: vre = 1'b1;
      S_VA2: begin
        vre = 1'b1;
        vra = slot_q[1];
      end
      S_W1: begin
        case (item_q.opcode)
          OP_INSERT: begin
            kwe = !match_q[0];
            kwd = item_q.key;
            vwe = !match_q[0];
          end
          OP_DELETE: kwe = 1'b1;
          OP_MODIFY: vwe = 1'b1;
          OP_REKEY: begin
            kwe = 1'b1;
            kwa = slot_q[1];
            kwd = item_q.second_key;
            vwe = 1'b1;
            vwa = slot_q[1];
            vwd = v1_q;
          end
          OP_SWAP: begin
            vwe = 1'b1;
            vwd = v2_q;
          end
          default: ;
        endcase
      end
      S_W2: begin
        case (item_q.opcode)
          OP_REKEY: kwe = 1'b1;
          OP_SWAP: begin
            vwe = 1'b1;
            vwa = slot_q[1];
            vwd = v1_q;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_SWEEP: if (sweep_q == ADDR_W'(DEPTH - 1)) state_d = item_q.opcode == OP_CLEAR &&
                                                            ok_q ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.opcode == OP_CLEAR) state_d = S_SWEEP;
          else if (in_item_i.opcode > OP_CLEAR || in_item_i.key == '0) state_d = S_DONE;
          else state_d = S_DIV;
        end
      end
      S_DIV: if (bit_q == 5'd0) state_d = S_PRD;
      S_PRD: state_d = S_PEV;
      S_PEV: begin
        if (!pmatch && !last_lay) begin
          state_d = S_PRD;
        end else if (!ph_q) begin
          case (item_q.opcode)
            OP_INSERT: state_d = (fin_match || fin_emp) ? S_VA1 : S_DONE;
            OP_REKEY, OP_SWAP:
              state_d = (fin_match && item_q.second_key != '0) ? S_DIV : S_DONE;
            default: state_d = fin_match ? S_VA1 : S_DONE;
          endcase
        end else begin
          if (item_q.opcode == OP_REKEY) state_d = (fin_emp && !fin_match) ? S_VA1 : S_DONE;
          else state_d = fin_match ? S_VA1 : S_DONE;
        end
      end
      S_VA1: state_d = S_VA2;
      S_VA2: state_d = S_VA3;
      S_VA3: state_d = S_W1;
      S_W1: state_d = S_W2;
      S_W2: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [63:0] lused_w, tused_w;
  logic [1:0]  hit_lay;
  assign hit_lay = (ok_q && item_q.opcode != OP_CLEAR) ? lay_q[0] : 2'd0;
  assign lused_w = 64'(cnt_q[hit_lay[LIX_W-1:0]]);
  assign tused_w = 64'(tot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      size_q[0]   <= RST_SIZE_0;
      size_q[1]   <= RST_SIZE_1;
      size_q[2]   <= RST_SIZE_2;
      size_q[3]   <= RST_SIZE_3;
      nlay_q      <= RST_LAYERS;
      for (int i = 0; i < NL; i++) cnt_q[i] <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      ph_q        <= 1'b0;
      item_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIZE_0: size_q[0] <= cfg_data_i;
          REG_SIZE_1: size_q[1] <= cfg_data_i;
          REG_SIZE_2: size_q[2] <= cfg_data_i;
          REG_SIZE_3: size_q[3] <= cfg_data_i;
          REG_LAYERS: nlay_q <= cfg_data_i[NLAY_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_SWEEP: sweep_q <= sweep_q + ADDR_W'(1);
        S_IDLE: begin
          if (in_valid_i) begin
            item_q   <= in_item_i;
            ph_q     <= 1'b0;
            bit_q    <= 5'd31;
            sweep_q  <= '0;
            match_q[0] <= 1'b0; match_q[1] <= 1'b0;
            emp_q[0]   <= 1'b0; emp_q[1]   <= 1'b0;
            lay_q[0]   <= 2'd0;
            ok_q     <= (in_item_i.opcode == OP_CLEAR);
            for (int i = 0; i < NL; i++) rem_q[i] <= '0;
            if (in_item_i.opcode == OP_CLEAR) begin
              for (int i = 0; i < NL; i++) cnt_q[i] <= '0;
              tot_q <= '0;
            end
          end
        end
        S_DIV: begin
          for (int i = 0; i < NL; i++) begin
            logic [SZ_W:0] t;
            logic [SZ_W:0] d;
            t = {rem_q[i], hsrc[bit_q]};
            d = {1'b0, eff_size(size_q[i])};
            rem_q[i] <= (t >= d) ? SZ_W'(t - d) : SZ_W'(t);
          end
          bit_q  <= bit_q - 5'd1;
          lcnt_q <= 2'd0;
        end
        S_PEV: begin
          if (pmatch) begin
            match_q[ph_q] <= 1'b1;
            slot_q[ph_q]  <= probe_addr;
            lay_q[ph_q]   <= lcnt_q;
          end else if (pemp && or_empty && !emp_q[ph_q]) begin
            emp_q[ph_q]  <= 1'b1;
            slot_q[ph_q] <= probe_addr;
            lay_q[ph_q]  <= lcnt_q;
          end
          lcnt_q <= lcnt_q + 2'd1;
          if (pmatch || last_lay) begin
            if (!ph_q && (item_q.opcode == OP_REKEY || item_q.opcode == OP_SWAP)) begin
              ph_q  <= 1'b1;
              bit_q <= 5'd31;
              for (int i = 0; i < NL; i++) rem_q[i] <= '0;
            end
          end
        end
        S_VA2: v1_q <= vrd_q;
        S_VA3: begin
          v2_q <= vrd_q;
          ok_q <= 1'b1;
        end
        S_W1: begin
          case (item_q.opcode)
            OP_INSERT: begin
              if (!match_q[0]) begin
                cnt_q[lay_q[0][LIX_W-1:0]] <= cnt_q[lay_q[0][LIX_W-1:0]] + CNT_W'(1);
                tot_q <= tot_q + TOT_W'(1);
              end
            end
            OP_DELETE: begin
              if (cnt_q[lay_q[0][LIX_W-1:0]] != '0)
                cnt_q[lay_q[0][LIX_W-1:0]] <= cnt_q[lay_q[0][LIX_W-1:0]] - CNT_W'(1);
              if (tot_q != '0) tot_q <= tot_q - TOT_W'(1);
            end
            OP_REKEY: begin
              cnt_q[lay_q[1][LIX_W-1:0]] <= cnt_q[lay_q[1][LIX_W-1:0]] + CNT_W'(1);
            end
            default: ;
          endcase
        end
        S_W2: begin
          if (item_q.opcode == OP_REKEY && cnt_q[lay_q[0][LIX_W-1:0]] != '0)
            cnt_q[lay_q[0][LIX_W-1:0]] <= cnt_q[lay_q[0][LIX_W-1:0]] - CNT_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q.ok    <= ok_q;
            out_q.old_value <= (ok_q && item_q.opcode != OP_CLEAR &&
                                !(item_q.opcode == OP_INSERT && !match_q[0])) ? v1_q : '0;
            out_q.hit_layer  <= hit_lay;
            out_q.layer_used <= (ok_q && item_q.opcode != OP_CLEAR) ?
                                lused_w[LUSED_W-1:0] : '0;
            out_q.total_used <= tused_w[TUSED_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule
